@@ rtl/kmnc_pkg.sv @@
`default_nettype none

package kmnc_pkg;

	localparam int DEF_MAX_CLUSTERS = 128;
	localparam int DEF_MAX_DIMS = 8;
	localparam int DEF_MAX_POINTS = 16384;
	localparam int DEF_COORD_BITS = 16;

	localparam int IN_COORDS = 8;
	localparam int COORD_IN_W = 16;
	localparam int CLUSTER_IDX_W = 7;
	localparam int POINT_IDX_W = 14;
	localparam int NEAREST_W = 7;
	localparam int DIST_W = 35;

	localparam int CLUSTERS_CFG_W = 8;
	localparam int DIMS_CFG_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS = 2'd1;

	localparam logic [CLUSTERS_CFG_W-1:0] RESET_CLUSTERS = 8'd75;
	localparam logic [DIMS_CFG_W-1:0] RESET_DIMS = 4'd8;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

endpackage

`default_nettype wire

@@ rtl/kmeans_nearest_centroid_core.sv @@
`default_nettype none

// Nearest-centroid engine for the k-means assignment step. After reset the block runs a
// clearing pass over every entry of the centroid and assignment stores with busy high;
// configuration writes are taken during that pass. A load item (mode 0) writes one centroid in
// the cycle it is accepted and leaves busy low. A classify item (mode 1) reads one centroid per
// cycle from the centroid memory into a shared distance unit, and holds busy high until the
// distances of all centroids in use have passed the distance pipeline and the best one is
// registered. The read rate is set by the single read port of the centroid memory, and the
// distance pipeline takes each centroid read from it in turn. Its
// result appears for exactly one cycle with done high, in the first cycle that busy is low
// again; the receiver must take it then, since the block cannot hold it.
module kmeans_nearest_centroid_core
	import kmnc_pkg::*;
#(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_DIMS = DEF_MAX_DIMS,
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     mode,
	input  wire logic [CLUSTER_IDX_W-1:0] cluster_index,
	input  wire logic [POINT_IDX_W-1:0]   point_index,
	input  wire logic [COORD_IN_W-1:0]    coord_0,
	input  wire logic [COORD_IN_W-1:0]    coord_1,
	input  wire logic [COORD_IN_W-1:0]    coord_2,
	input  wire logic [COORD_IN_W-1:0]    coord_3,
	input  wire logic [COORD_IN_W-1:0]    coord_4,
	input  wire logic [COORD_IN_W-1:0]    coord_5,
	input  wire logic [COORD_IN_W-1:0]    coord_6,
	input  wire logic [COORD_IN_W-1:0]    coord_7,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	output logic                          done,
	output logic [NEAREST_W-1:0]          nearest,
	output logic [DIST_W-1:0]             min_sq_distance,
	output logic                          changed
);

	localparam int CW = $clog2(MAX_CLUSTERS);
	localparam int PW = $clog2(MAX_POINTS);
	localparam int CB = COORD_BITS;
	localparam int PRODW = 2 * CB;
	localparam int LV = $clog2(MAX_DIMS);
	localparam int P = 1 << LV;
	localparam int NS = 3 + LV;
	localparam int TW = DIST_W + 1 + LV;
	localparam int AW = CW + 1;
	localparam int DW = $clog2(MAX_DIMS + 1);
	localparam int CLR_N = (MAX_POINTS > MAX_CLUSTERS) ? MAX_POINTS : MAX_CLUSTERS;
	localparam int CLRW = $clog2(CLR_N);

	localparam logic [TW-1:0] TERM_CAP = TW'(1) << DIST_W;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RUN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [CLRW-1:0] clr_q;
	logic issue_q;
	logic [CW-1:0] rd_cnt_q;
	logic [NS-1:0] vld_s;
	logic done_q;
	logic [CLUSTERS_CFG_W-1:0] clusters_q;
	logic [DIMS_CFG_W-1:0] dims_cfg_q;

	logic [CW-1:0] last_q;
	logic [DW-1:0] dims_q;
	logic [MAX_DIMS*CB-1:0] pt_q;
	logic [PW-1:0] pidx_q;
	logic in_range_q;
	logic [AW-1:0] asg_rd_q;

	logic [MAX_DIMS*CB-1:0] cent_mem [MAX_CLUSTERS];
	logic [AW-1:0] asg_mem [MAX_POINTS];

	logic [MAX_DIMS*CB-1:0] cent_s1;
	logic [PRODW-1:0] prod_s2 [MAX_DIMS];
	logic [TW-1:0] tree_s [LV+1][P];
	logic [CW-1:0] idx_s [NS];

	logic [DIST_W-1:0] best_q;
	logic [CW-1:0] best_idx_q;
	logic [NEAREST_W-1:0] nearest_q;
	logic [DIST_W-1:0] dist_q;
	logic changed_q;

	logic [COORD_IN_W-1:0] coord_in [IN_COORDS];
	logic [MAX_DIMS*CB-1:0] pt_word;
	logic accept;
	logic load_wr;
	logic cls_acc;
	logic clearing;
	logic clr_in_cent;
	logic clr_in_pts;
	logic [CW-1:0] k_last;
	logic [DW-1:0] dims_eff;
	logic asg_we;
	logic [PW-1:0] asg_waddr;
	logic [AW-1:0] asg_wdata;
	logic [TW-1:0] tsum;
	logic [DIST_W-1:0] dist_sat;

	assign coord_in[0] = coord_0;
	assign coord_in[1] = coord_1;
	assign coord_in[2] = coord_2;
	assign coord_in[3] = coord_3;
	assign coord_in[4] = coord_4;
	assign coord_in[5] = coord_5;
	assign coord_in[6] = coord_6;
	assign coord_in[7] = coord_7;

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_pt
		if (d < IN_COORDS) begin : g_in
			assign pt_word[d*CB +: CB] = CB'(coord_in[d]);
		end else begin : g_zero
			assign pt_word[d*CB +: CB] = '0;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;
	assign load_wr = accept && (mode == MODE_LOAD) && (32'(cluster_index) < MAX_CLUSTERS);
	assign cls_acc = accept && (mode == MODE_CLASSIFY);
	assign clearing = (state_q == ST_CLEAR);
	assign clr_in_cent = (32'(clr_q) < MAX_CLUSTERS);
	assign clr_in_pts = (32'(clr_q) < MAX_POINTS);

	always_comb begin
		if (clusters_q == '0) begin
			k_last = '0;
		end else if (32'(clusters_q) > MAX_CLUSTERS) begin
			k_last = CW'(MAX_CLUSTERS - 1);
		end else begin
			k_last = CW'(clusters_q - 1'b1);
		end
		if (dims_cfg_q == '0) begin
			dims_eff = DW'(1);
		end else if (32'(dims_cfg_q) > MAX_DIMS) begin
			dims_eff = DW'(MAX_DIMS);
		end else begin
			dims_eff = DW'(dims_cfg_q);
		end
	end

	assign asg_we = (clearing && clr_in_pts) || ((state_q == ST_DONE) && in_range_q);
	assign asg_waddr = clearing ? clr_q[PW-1:0] : pidx_q;
	assign asg_wdata = clearing ? '0 : {1'b1, best_idx_q};

	always_ff @(posedge clk) begin
		if (clearing && clr_in_cent) begin
			cent_mem[clr_q[CW-1:0]] <= '0;
		end else if (load_wr) begin
			cent_mem[CW'(cluster_index)] <= pt_word;
		end
		cent_s1 <= cent_mem[rd_cnt_q];
	end

	always_ff @(posedge clk) begin
		if (asg_we) begin
			asg_mem[asg_waddr] <= asg_wdata;
		end
		if (cls_acc) begin
			asg_rd_q <= asg_mem[PW'(point_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			issue_q <= 1'b0;
			rd_cnt_q <= '0;
			vld_s <= '0;
			done_q <= 1'b0;
			clusters_q <= RESET_CLUSTERS;
			dims_cfg_q <= RESET_DIMS;
		end else begin
			done_q <= 1'b0;
			vld_s <= {vld_s[NS-2:0], issue_q};
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_CLUSTERS: clusters_q <= cfg_data[CLUSTERS_CFG_W-1:0];
					REG_DIMS: dims_cfg_q <= cfg_data[DIMS_CFG_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLRW'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cls_acc) begin
						state_q <= ST_RUN;
						issue_q <= 1'b1;
						rd_cnt_q <= '0;
					end
				end
				ST_RUN: begin
					if (issue_q) begin
						if (rd_cnt_q == last_q) begin
							issue_q <= 1'b0;
						end else begin
							rd_cnt_q <= rd_cnt_q + 1'b1;
						end
					end
					if (vld_s[NS-1] && (idx_s[NS-1] == last_q)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cls_acc) begin
			pt_q <= pt_word;
			pidx_q <= PW'(point_index);
			in_range_q <= (32'(point_index) < MAX_POINTS);
			last_q <= k_last;
			dims_q <= dims_eff;
		end
		idx_s[0] <= rd_cnt_q;
		for (int s = 1; s < NS; s++) begin
			idx_s[s] <= idx_s[s-1];
		end
	end

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
		logic [CB-1:0] a;
		logic [CB-1:0] b;
		logic [CB-1:0] diff;

		assign a = cent_s1[d*CB +: CB];
		assign b = pt_q[d*CB +: CB];
		assign diff = (a > b) ? (a - b) : (b - a);

		always_ff @(posedge clk) begin
			if (dims_q > DW'(d)) begin
				prod_s2[d] <= PRODW'(diff) * PRODW'(diff);
			end else begin
				prod_s2[d] <= '0;
			end
		end
	end

	for (genvar i = 0; i < P; i++) begin : g_term
		if (i < MAX_DIMS) begin : g_used
			always_ff @(posedge clk) begin
				if (|(prod_s2[i] >> DIST_W)) begin
					tree_s[0][i] <= TERM_CAP;
				end else begin
					tree_s[0][i] <= TW'(prod_s2[i]);
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				tree_s[0][i] <= '0;
			end
		end
	end

	for (genvar l = 1; l <= LV; l++) begin : g_level
		for (genvar i = 0; i < (P >> l); i++) begin : g_node
			always_ff @(posedge clk) begin
				tree_s[l][i] <= tree_s[l-1][2*i] + tree_s[l-1][2*i+1];
			end
		end
	end

	assign tsum = tree_s[LV][0];
	assign dist_sat = (|(tsum >> DIST_W)) ? DIST_MAX : tsum[DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (vld_s[NS-1] && ((idx_s[NS-1] == '0) || (dist_sat < best_q))) begin
			best_q <= dist_sat;
			best_idx_q <= idx_s[NS-1];
		end
		if (state_q == ST_DONE) begin
			nearest_q <= NEAREST_W'(best_idx_q);
			dist_q <= best_q;
			changed_q <= in_range_q && (!asg_rd_q[CW] || (asg_rd_q[CW-1:0] != best_idx_q));
		end
	end

	assign done = done_q;
	assign nearest = nearest_q;
	assign min_sq_distance = dist_q;
	assign changed = changed_q;

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE))
		else $error("result strobe without a finished search");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && issue_q) |-> (rd_cnt_q <= last_q))
		else $error("centroid read address past the last centroid in use");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (vld_s == '0 && !issue_q))
		else $error("distance pipeline busy while idle");

	a_changed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && changed) |-> in_range_q)
		else $error("changed reported for a point outside the assignment store");

endmodule

`default_nettype wire

@@ test/tb_kmeans_nearest_centroid_core.sv @@
`timescale 1ns / 100ps

module tb_kmeans_nearest_centroid_core;
	import kmnc_pkg::*;

	localparam int SETTLE_CYCLES = 150;
	localparam int PHASE_ITEMS = 104;
	localparam int NUM_PHASES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [35:0] DIST_LIMIT = (36'd1 << DIST_W) - 36'd1;

	typedef logic [IN_COORDS-1:0][COORD_IN_W-1:0] coords_t;

	typedef struct packed {
		logic mode;
		logic [CLUSTER_IDX_W-1:0] cluster;
		logic [POINT_IDX_W-1:0] point;
		coords_t coord;
	} work_item_t;

	typedef struct packed {
		logic [NEAREST_W-1:0] nearest;
		logic [DIST_W-1:0] sq_dist;
		logic changed;
	} assignment_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	work_item_t drive_item = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic done;
	logic [NEAREST_W-1:0] nearest;
	logic [DIST_W-1:0] min_sq_distance;
	logic changed;

	coords_t centroid_mem [DEF_MAX_CLUSTERS];
	logic point_seen [DEF_MAX_POINTS];
	logic [NEAREST_W-1:0] point_cluster [DEF_MAX_POINTS];
	logic [CLUSTERS_CFG_W-1:0] clusters_reg = RESET_CLUSTERS;
	logic [DIMS_CFG_W-1:0] dims_reg = RESET_DIMS;

	work_item_t queued_items [$];
	assignment_t pending_assignments [$];
	logic item_taken = 1'b0;
	int sender_idle_pct = 35;
	int mismatches = 0;
	int results_checked = 0;
	int loads_seen = 0;
	int classifies_seen = 0;
	int settings_used = 0;

	kmeans_nearest_centroid_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(drive_item.mode),
		.cluster_index(drive_item.cluster),
		.point_index(drive_item.point),
		.coord_0(drive_item.coord[0]),
		.coord_1(drive_item.coord[1]),
		.coord_2(drive_item.coord[2]),
		.coord_3(drive_item.coord[3]),
		.coord_4(drive_item.coord[4]),
		.coord_5(drive_item.coord[5]),
		.coord_6(drive_item.coord[6]),
		.coord_7(drive_item.coord[7]),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.nearest(nearest),
		.min_sq_distance(min_sq_distance),
		.changed(changed)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic int active_clusters();
		if (clusters_reg == 0)
			return 1;
		if (clusters_reg > DEF_MAX_CLUSTERS)
			return DEF_MAX_CLUSTERS;
		return clusters_reg;
	endfunction

	function automatic int active_dims();
		if (dims_reg == 0)
			return 1;
		if (dims_reg > DEF_MAX_DIMS)
			return DEF_MAX_DIMS;
		return dims_reg;
	endfunction

	function automatic assignment_t nearest_centroid(input work_item_t it);
		assignment_t res;
		logic [35:0] sum;
		logic [35:0] best_dist;
		logic [35:0] term;
		logic [COORD_IN_W-1:0] diff;
		int best;
		int k;
		int dims;
		k = active_clusters();
		dims = active_dims();
		best = 0;
		best_dist = '0;
		for (int c = 0; c < k; c++) begin
			sum = '0;
			for (int d = 0; d < dims; d++) begin
				if (centroid_mem[c][d] > it.coord[d])
					diff = centroid_mem[c][d] - it.coord[d];
				else
					diff = it.coord[d] - centroid_mem[c][d];
				term = 36'(diff) * 36'(diff);
				sum = sum + term;
				if (sum > DIST_LIMIT)
					sum = DIST_LIMIT;
			end
			if (c == 0 || sum < best_dist) begin
				best_dist = sum;
				best = c;
			end
		end
		res.nearest = NEAREST_W'(best);
		res.sq_dist = best_dist[DIST_W-1:0];
		res.changed = !point_seen[it.point] || point_cluster[it.point] != res.nearest;
		point_seen[it.point] = 1'b1;
		point_cluster[it.point] = res.nearest;
		return res;
	endfunction

	always @(posedge clk) begin
		assignment_t want;
		if (arst_n) begin
			item_taken = start && !busy;
			if (done) begin
				if (pending_assignments.size() == 0) begin
					report_mismatch($sformatf("result nearest=%0d with no item pending", nearest));
				end else begin
					want = pending_assignments.pop_front();
					results_checked++;
					if (nearest !== want.nearest)
						report_mismatch($sformatf("nearest %0d, expected %0d",
							nearest, want.nearest));
					if (min_sq_distance !== want.sq_dist)
						report_mismatch($sformatf("min_sq_distance %0d, expected %0d",
							min_sq_distance, want.sq_dist));
					if (changed !== want.changed)
						report_mismatch($sformatf("changed %0b, expected %0b",
							changed, want.changed));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CLUSTERS: clusters_reg = cfg_data;
					REG_DIMS: dims_reg = cfg_data[DIMS_CFG_W-1:0];
					default: ;
				endcase
			end
			if (item_taken) begin
				if (drive_item.mode == MODE_LOAD) begin
					centroid_mem[drive_item.cluster] = drive_item.coord;
					loads_seen++;
				end else begin
					pending_assignments.push_back(nearest_centroid(drive_item));
					classifies_seen++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!start || item_taken)) begin
			if (queued_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				drive_item <= queued_items.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic void push_item(input logic m, input int slot, input int pt,
		input coords_t crd);
		work_item_t it;
		it.mode = m;
		it.cluster = CLUSTER_IDX_W'(slot);
		it.point = POINT_IDX_W'(pt);
		it.coord = crd;
		queued_items.push_back(it);
	endfunction

	function automatic coords_t random_coords();
		coords_t crd;
		for (int d = 0; d < IN_COORDS; d++) begin
			case ($urandom_range(9))
				0: crd[d] = '0;
				1: crd[d] = '1;
				default: crd[d] = COORD_IN_W'($urandom_range(65535));
			endcase
		end
		return crd;
	endfunction

	function automatic coords_t near_coords(input int slot);
		coords_t crd;
		int v;
		for (int d = 0; d < IN_COORDS; d++) begin
			v = int'(centroid_mem[slot][d]) + $urandom_range(64) - 32;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			crd[d] = COORD_IN_W'(v);
		end
		return crd;
	endfunction

	task automatic drain();
		while (queued_items.size() != 0 || start || pending_assignments.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] clusters,
		input logic [CFG_DATA_W-1:0] dims);
		drain();
		write_reg(REG_CLUSTERS, clusters);
		write_reg(REG_DIMS, dims);
		settings_used++;
	endtask

	function automatic void random_phase(input int n);
		int k;
		int slot;
		for (int i = 0; i < n; i++) begin
			k = active_clusters();
			if ($urandom_range(99) < 30) begin
				slot = $urandom_range(99) < 80 ? $urandom_range(k - 1) : $urandom_range(127);
				if ($urandom_range(99) < 15)
					push_item(MODE_LOAD, slot, 0, centroid_mem[$urandom_range(k - 1)]);
				else
					push_item(MODE_LOAD, slot, $urandom_range(16383), random_coords());
			end else begin
				case ($urandom_range(9))
					0: slot = 16383;
					1, 2: slot = $urandom_range(16383);
					default: slot = $urandom_range(63);
				endcase
				if ($urandom_range(1) == 1)
					push_item(MODE_CLASSIFY, $urandom_range(127), slot,
						near_coords($urandom_range(k - 1)));
				else
					push_item(MODE_CLASSIFY, $urandom_range(127), slot, random_coords());
			end
		end
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] phase_clusters [NUM_PHASES];
		logic [CFG_DATA_W-1:0] phase_dims [NUM_PHASES];
		coords_t alt;
		phase_clusters = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd8, 8'd37, 8'd100, 8'd4};
		phase_dims = '{8'd1, 8'd8, 8'd0, 8'd255, 8'd3, 8'd5, 8'd7, 8'd2};
		alt = {IN_COORDS / 2{16'hAAAA, 16'h5555}};
		for (int c = 0; c < DEF_MAX_CLUSTERS; c++)
			centroid_mem[c] = '0;
		for (int p = 0; p < DEF_MAX_POINTS; p++) begin
			point_seen[p] = 1'b0;
			point_cluster[p] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_item(MODE_CLASSIFY, 0, 0, '0);
		push_item(MODE_CLASSIFY, 127, 0, '0);
		push_item(MODE_CLASSIFY, 0, 16383, '1);
		push_item(MODE_LOAD, 127, 16383, '1);
		push_item(MODE_LOAD, 74, 0, '1);
		push_item(MODE_CLASSIFY, 0, 16383, '1);
		push_item(MODE_LOAD, 3, 0, '1);
		push_item(MODE_CLASSIFY, 0, 16383, '1);
		push_item(MODE_CLASSIFY, 0, 1, alt);
		push_item(MODE_LOAD, 10, 0, ~alt);
		push_item(MODE_CLASSIFY, 0, 1, ~alt);
		configure(8'd128, 8'd1);
		write_reg(REG_UNUSED, 8'hFF);
		push_item(MODE_CLASSIFY, 0, 2, coords_t'(16'hFFFF));
		push_item(MODE_LOAD, 127, 0, {{IN_COORDS - 1{16'hFFFF}}, 16'h0000});
		push_item(MODE_CLASSIFY, 0, 2, '0);
		configure(8'd0, 8'd0);
		push_item(MODE_CLASSIFY, 0, 3, random_coords());
		push_item(MODE_CLASSIFY, 0, 3, random_coords());
		configure(8'd255, 8'd255);
		push_item(MODE_CLASSIFY, 0, 16383, '0);
		push_item(MODE_CLASSIFY, 0, 5, '1);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			configure(phase_clusters[ph], phase_dims[ph]);
			if (ph < 3)
				sender_idle_pct = 35;
			else if (ph < 6)
				sender_idle_pct = 85;
			else
				sender_idle_pct = 0;
			random_phase(PHASE_ITEMS);
		end
		drain();

		$display("Ran %0d centroid loads and %0d point classifications over %0d settings.",
			loads_seen, classifies_seen, settings_used);
		$display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#4000000;
		$display("Timed out with %0d items queued and %0d results outstanding.",
			queued_items.size(), pending_assignments.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/kmnc_pkg.sv
rtl/kmeans_nearest_centroid_core.sv
test/tb_kmeans_nearest_centroid_core.sv
